// ===== hw/rtl/rrm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrm_pkg
// Shared types and constants of the 3x3 raster regularity mask.
// ----------------------------------------------------------------------------
package rrm_pkg;

   localparam int SAMPLE_BITS      = 32;
   localparam int DEFAULT_MAX_COLS = 4096;
   localparam int NEIGHBOURS       = 8;

   localparam int COLS_BITS    = 13;
   localparam int ROWS_BITS    = 16;
   localparam int THRESH_BITS  = 31;
   localparam int COL_OUT_BITS = 12;
   localparam int CSR_BITS     = 32;
   localparam int CSR_ADDR_BITS = 4;

   // abs difference fits SAMPLE_BITS unsigned, eight of them add three bits
   localparam int SUM_BITS  = SAMPLE_BITS + 3;
   localparam int USED_BITS = 4;
   localparam int PROD_BITS = THRESH_BITS + USED_BITS;
   localparam int CMP_BITS  = (SUM_BITS > PROD_BITS) ? SUM_BITS : PROD_BITS;

   localparam int REQ_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 1 + ROWS_BITS + COL_OUT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_FIELD_BITS;

   localparam logic [COLS_BITS-1:0]   IMAGE_COLS_RESET   = 13'd4096;
   localparam logic [ROWS_BITS-1:0]   IMAGE_ROWS_RESET   = 16'd1024;
   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET    = 31'd256;
   localparam logic [SAMPLE_BITS-1:0] NODATA_LEVEL_RESET = 32'hFF80_0000;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [1:0] {
      REG_IMAGE_COLS,
      REG_IMAGE_ROWS,
      REG_THRESHOLD,
      REG_NODATA_LEVEL
   } reg_index_type;

   // one line store word: the samples of rows r-2 and r-1 for one column
   typedef struct packed {
      sample_type upper;
      sample_type middle;
   } ls_word_type;

endpackage

// ===== hw/rtl/raster_regularity_mask_3x3.sv =====
// ----------------------------------------------------------------------------
// raster_regularity_mask_3x3
// Marks interior pixels of a raster surface model whose mean absolute
// difference to their valid 3x3 neighbours lies below a threshold.
// ----------------------------------------------------------------------------
// Samples arrive in raster order, one per clock, on the req stream; the block
// takes a new sample every cycle unless the rsp side stalls. The sample at
// row r, column c completes the window of the centre at (r-1, c-1), whose
// result is scored from stage one and then held in the output register.
// Border pixels give no result, so a full image of R rows and C columns gives
// (R-2)*(C-2) results, the last one flagged on tlast. Two lines of MAX_COLS
// samples sit in one memory with a registered read port; its contents need no
// clearing after reset and the block is ready straight away. The user must
// write the register file only while the stream is idle; no check enforces it.
// ----------------------------------------------------------------------------
module raster_regularity_mask_3x3 import rrm_pkg::*; #(
   parameter int MAX_COLS = DEFAULT_MAX_COLS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // [31:0] elevation
   input  logic                      req_tuser,   // [0] start_of_image
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] regular_flag, [16:1] pixel_row, [28:17] pixel_col, [31:29] zero
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tlast,   // last_result
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_BITS-1:0]       csr_pwdata,
   output logic [CSR_BITS-1:0]       csr_prdata,
   output logic                      csr_pready
);

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int CAP_W   = $clog2(MAX_COLS + 1);
   localparam int EFF_W   = (CAP_W > COLS_BITS) ? CAP_W : COLS_BITS;
   localparam int ROW_X_W = ROWS_BITS + 1;
   localparam logic [EFF_W-1:0] MIN_COLS  = EFF_W'(3);
   localparam logic [EFF_W-1:0] MAX_EFF   = EFF_W'(MAX_COLS);
   localparam logic [ROWS_BITS-1:0] MIN_ROWS = ROWS_BITS'(3);
   localparam logic [COL_W-1:0] FIRST_COL = COL_W'(2);
   localparam logic [ROWS_BITS-1:0] FIRST_ROW = ROWS_BITS'(2);

   // register file
   logic [COLS_BITS-1:0]   image_cols_ff;
   logic [ROWS_BITS-1:0]   image_rows_ff;
   logic [THRESH_BITS-1:0] threshold_ff;
   sample_type             nodata_level_ff;
   logic                   csr_write;
   reg_index_type          csr_index;

   // counters and stage one
   logic [COL_W-1:0]     col_cnt_ff, col_cnt_in;
   logic [ROWS_BITS-1:0] row_cnt_ff, row_cnt_in;
   logic [COL_W-1:0]     cur_col;
   logic [ROWS_BITS-1:0] cur_row;
   logic                 col_wrap, row_wrap;
   logic [EFF_W-1:0]     eff_cols;
   logic [ROWS_BITS-1:0] eff_rows;

   logic                 s1_valid_ff, s1_valid_in;
   sample_type           s1_cur_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [ROWS_BITS-1:0] s1_row_ff;
   logic                 fwd_ff, fwd_in;
   ls_word_type          fwd_word_ff;

   logic                 req_accept;
   logic                 out_free;
   logic                 s1_retire;
   ls_word_type          rd_word;
   ls_word_type          line_word;
   ls_word_type          wr_word;

   sample_type           win_ff [6];
   sample_type           neighbour [NEIGHBOURS];
   logic                 regular;
   logic                 emit;
   logic                 is_last;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_flag_ff;
   logic [ROWS_BITS-1:0]    rsp_row_ff;
   logic [COL_OUT_BITS-1:0] rsp_col_ff;
   logic                    rsp_last_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_cols_ff   <= IMAGE_COLS_RESET;
         image_rows_ff   <= IMAGE_ROWS_RESET;
         threshold_ff    <= THRESHOLD_RESET;
         nodata_level_ff <= NODATA_LEVEL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_COLS:   image_cols_ff   <= csr_pwdata[COLS_BITS-1:0];
            REG_IMAGE_ROWS:   image_rows_ff   <= csr_pwdata[ROWS_BITS-1:0];
            REG_THRESHOLD:    threshold_ff    <= csr_pwdata[THRESH_BITS-1:0];
            REG_NODATA_LEVEL: nodata_level_ff <= csr_pwdata[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_COLS:   csr_prdata = CSR_BITS'(image_cols_ff);
         REG_IMAGE_ROWS:   csr_prdata = CSR_BITS'(image_rows_ff);
         REG_THRESHOLD:    csr_prdata = CSR_BITS'(threshold_ff);
         REG_NODATA_LEVEL: csr_prdata = CSR_BITS'(nodata_level_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // sizes at least three; columns also saturated to what the line store can hold
   always_comb begin
      if (EFF_W'(image_cols_ff) < MIN_COLS) begin
         eff_cols = MIN_COLS;
      end else if (EFF_W'(image_cols_ff) > MAX_EFF) begin
         eff_cols = MAX_EFF;
      end else begin
         eff_cols = EFF_W'(image_cols_ff);
      end
      eff_rows = (image_rows_ff < MIN_ROWS) ? MIN_ROWS : image_rows_ff;
   end

   // ---------------------------------------------------------------- input
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_retire  = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_retire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      cur_col  = req_tuser ? '0 : col_cnt_ff;
      cur_row  = req_tuser ? '0 : row_cnt_ff;
      col_wrap = (EFF_W'(cur_col) + EFF_W'(1)) >= eff_cols;
      row_wrap = (ROW_X_W'(cur_row) + ROW_X_W'(1)) >= ROW_X_W'(eff_rows);
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (req_accept) begin
         if (col_wrap) begin
            col_cnt_in = '0;
            row_cnt_in = row_wrap ? '0 : cur_row + ROWS_BITS'(1);
         end else begin
            col_cnt_in = cur_col + COL_W'(1);
            row_cnt_in = cur_row;
         end
      end
      s1_valid_in = req_accept || (s1_valid_ff && !s1_retire);
      // the word being written back this cycle is missed by the read
      fwd_in = s1_retire && (s1_col_ff == cur_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cur_ff   <= req_tdata[SAMPLE_BITS-1:0];
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row;
         fwd_ff      <= fwd_in;
         fwd_word_ff <= wr_word;
      end
   end

   // ---------------------------------------------------------------- lines
   rrm_line_store #(
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock      (clock),
      .rd_en      (req_accept),
      .rd_addr    (cur_col),
      .rd_data_ff (rd_word),
      .wr_en      (s1_retire),
      .wr_addr    (s1_col_ff),
      .wr_data    (wr_word)
   );

   assign line_word     = fwd_ff ? fwd_word_ff : rd_word;
   assign wr_word.upper  = line_word.middle;
   assign wr_word.middle = s1_cur_ff;

   // ---------------------------------------------------------------- window
   // [0..2] column c-1 (upper, centre row, lower), [3..5] column c-2
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_retire) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= line_word.upper;
         win_ff[1] <= line_word.middle;
         win_ff[2] <= s1_cur_ff;
      end
   end

   assign neighbour[0] = win_ff[3];
   assign neighbour[1] = win_ff[4];
   assign neighbour[2] = win_ff[5];
   assign neighbour[3] = win_ff[0];
   assign neighbour[4] = win_ff[2];
   assign neighbour[5] = line_word.upper;
   assign neighbour[6] = line_word.middle;
   assign neighbour[7] = s1_cur_ff;

   rrm_score u_score (
      .centre       (win_ff[1]),
      .neighbour    (neighbour),
      .nodata_level (nodata_level_ff),
      .threshold    (threshold_ff),
      .regular      (regular)
   );

   assign emit = (s1_col_ff >= FIRST_COL) && (EFF_W'(s1_col_ff) < eff_cols)
              && (s1_row_ff >= FIRST_ROW)
              && (ROW_X_W'(s1_row_ff) < ROW_X_W'(eff_rows));
   assign is_last = ((EFF_W'(s1_col_ff) + EFF_W'(1)) == eff_cols)
                 && ((ROW_X_W'(s1_row_ff) + ROW_X_W'(1)) == ROW_X_W'(eff_rows));

   // ---------------------------------------------------------------- output
   assign rsp_valid_in = s1_retire ? emit : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_retire && emit) begin
         rsp_flag_ff <= regular;
         rsp_row_ff  <= s1_row_ff - ROWS_BITS'(1);
         rsp_col_ff  <= COL_OUT_BITS'(s1_col_ff - COL_W'(1));
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_col_ff, rsp_row_ff, rsp_flag_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/rrm_line_store.sv =====
// ----------------------------------------------------------------------------
// rrm_line_store
// Two raster lines held as one word per column, one read and one write port.
// ----------------------------------------------------------------------------
module rrm_line_store import rrm_pkg::*; #(
   parameter int DEPTH = DEFAULT_MAX_COLS
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output ls_word_type              rd_data_ff,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  ls_word_type              wr_data
);

   ls_word_type mem_array [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   // read returns the old word when the same address is written in the cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/rrm_score.sv =====
// ----------------------------------------------------------------------------
// rrm_score
// Sum of absolute neighbour differences and the regularity compare.
// ----------------------------------------------------------------------------
module rrm_score import rrm_pkg::*; (
   input  sample_type             centre,
   input  sample_type             neighbour [NEIGHBOURS],
   input  sample_type             nodata_level,
   input  logic [THRESH_BITS-1:0] threshold,
   output logic                   regular
);

   logic                          centre_ok;
   logic [NEIGHBOURS-1:0]         nb_ok;
   logic signed [SAMPLE_BITS:0]   diff      [NEIGHBOURS];
   logic [SAMPLE_BITS-1:0]        abs_diff  [NEIGHBOURS];
   logic [SAMPLE_BITS:0]          pair_sum  [NEIGHBOURS/2];
   logic [SAMPLE_BITS+1:0]        quad_sum  [NEIGHBOURS/4];
   logic [SUM_BITS-1:0]           total;
   logic [USED_BITS-1:0]          used;
   logic [PROD_BITS-1:0]          limit;

   always_comb begin
      centre_ok = centre > nodata_level;
      for (int k = 0; k < NEIGHBOURS; k++) begin
         nb_ok[k] = centre_ok && (neighbour[k] > nodata_level);
         diff[k]  = {neighbour[k][SAMPLE_BITS-1], neighbour[k]}
                  - {centre[SAMPLE_BITS-1], centre};
         if (!nb_ok[k]) begin
            abs_diff[k] = '0;
         end else if (diff[k][SAMPLE_BITS]) begin
            abs_diff[k] = SAMPLE_BITS'(-diff[k]);
         end else begin
            abs_diff[k] = SAMPLE_BITS'(diff[k]);
         end
      end
      for (int i = 0; i < NEIGHBOURS/2; i++) begin
         pair_sum[i] = {1'b0, abs_diff[2*i]} + {1'b0, abs_diff[2*i+1]};
      end
      for (int i = 0; i < NEIGHBOURS/4; i++) begin
         quad_sum[i] = {1'b0, pair_sum[2*i]} + {1'b0, pair_sum[2*i+1]};
      end
      total = {1'b0, quad_sum[0]} + {1'b0, quad_sum[1]};
      used  = USED_BITS'($countones(nb_ok));
      limit = PROD_BITS'(threshold) * PROD_BITS'(used);
      // no valid neighbour or a no-data centre gives 0 < 0, so never regular
      regular = CMP_BITS'(total) < CMP_BITS'(limit);
   end

endmodule

// ===== hw/rtl/rrm_checker.sv =====
// ----------------------------------------------------------------------------
// rrm_port_checker
// Port-level checks of the raster regularity mask, bound to the top level.
// ----------------------------------------------------------------------------
module rrm_port_checker import rrm_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                      rsp_tlast,
   input logic                      csr_psel,
   input logic                      csr_penable,
   input logic                      csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input logic [CSR_BITS-1:0]       csr_pwdata,
   input logic [CSR_BITS-1:0]       csr_prdata,
   input logic                      csr_pready
);

   // a stalled result transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // with room on the result side the input never stalls
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("req_tready low with output free");

   // result rows are never row zero and the padding stays clear
   a_rsp_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[ROWS_BITS:1] != '0
         && rsp_tdata[RSP_TDATA_BITS-1:RSP_FIELD_BITS] == '0)
      else $error("result row outside interior or padding set");

   // the validity level reads back as written
   a_nodata_rb: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
         && csr_paddr[CSR_ADDR_BITS-1:2] == REG_NODATA_LEVEL)
      ##1 (csr_paddr[CSR_ADDR_BITS-1:2] == REG_NODATA_LEVEL)
      |-> csr_prdata == $past(csr_pwdata))
      else $error("nodata_level read back mismatch");

endmodule

bind raster_regularity_mask_3x3 rrm_port_checker u_rrm_checker (.*);
